// ===== design/nmc_pkg.sv =====
`default_nettype none
package nmc_pkg;
  localparam int MAX_CLASSES  = 8;
  localparam int MAX_FEATURES = 16;
  localparam int CLS_W  = $clog2(MAX_CLASSES);
  localparam int FEAT_W = $clog2(MAX_FEATURES);
  localparam int ADDR_W = CLS_W + FEAT_W;
  localparam int DEPTH  = MAX_CLASSES * MAX_FEATURES;

  localparam logic [1:0] OP_CLEAR    = 2'd0;
  localparam logic [1:0] OP_TRAIN    = 2'd1;
  localparam logic [1:0] OP_FINALIZE = 2'd2;
  localparam logic [1:0] OP_CLASSIFY = 2'd3;

  localparam logic [1:0] CFG_NUM_CLASSES  = 2'd0;
  localparam logic [1:0] CFG_NUM_FEATURES = 2'd1;
endpackage
`default_nettype wire

// ===== design/nmc_ram.sv =====
`default_nettype none
module nmc_ram #(
  parameter int Width = 16,
  parameter int Depth = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== design/nearest_mean_classifier.sv =====
// Channel   Direction  Signals
// in        input      in_valid_i/in_ready_o, opcode_i, class_index_i, feature_value_i
// out       output     out_valid_o/out_ready_i, best_class_o, best_distance_o, no_class_o
// cfg       input      cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i
//
// Clear, and a training beat for an unused or saturated class, stay in idle; a training beat
// that updates a sum does a sum memory read, then write. A classify beat runs read, difference,
// square and accumulate for each of the 8 classes with one squarer, plus a search and a load
// state on the last feature of a sample. Finalize walks all 128 means through the bit-serial
// divider, skipping it for an empty class. Reset needs no clearing pass; valid bits stand for
// the zeroed memories. A held result holds the next one in the load state, blocking input.
`default_nettype none
module nearest_mean_classifier (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [2:0]  class_index_i,
  input  wire logic signed [15:0] feature_value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       best_class_o,
  output logic [35:0]      best_distance_o,
  output logic             no_class_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [4:0]  cfg_data_i
);
  import nmc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_T_RD, ST_T_WR, ST_F_RD, ST_F_LD, ST_DIV, ST_F_WR,
    ST_C_RD, ST_C_DF, ST_C_SQ, ST_C_AC, ST_SRCH, ST_DONE
  } state_e;

  localparam logic [36:0] ACC_MAX  = {37{1'b1}};
  localparam logic [35:0] DIST_MAX = {36{1'b1}};

  state_e state_q;
  logic [3:0] ncls_q;
  logic [4:0] nfeat_q;
  logic [FEAT_W-1:0] pos_q, ipos_q;
  logic [CLS_W-1:0]  cls_q, cnt_q;
  logic signed [15:0] x_q;
  logic last_q;
  logic [ADDR_W-1:0] ent_q;
  logic [15:0] counts_q [MAX_CLASSES];
  logic [36:0] acc_q [MAX_CLASSES];
  logic [DEPTH-1:0] sum_vld_q, mean_vld_q;
  logic [31:0] dvd_q;
  logic [15:0] rem_q, den_q;
  logic neg_q;
  logic [4:0] bit_q;
  logic signed [16:0] d_q;
  logic [33:0] sq_q;
  logic found_q;
  logic [CLS_W-1:0] bcls_q;
  logic [36:0] bdist_q;

  logic [CLS_W:0]  effc;
  logic [FEAT_W:0] efff;
  logic [FEAT_W-1:0] pos_n, pos_adv;
  logic last_n;

  always_comb begin
    if (ncls_q == 4'd0) effc = (CLS_W+1)'(1);
    else if ({1'b0, ncls_q} > 5'(MAX_CLASSES)) effc = (CLS_W+1)'(MAX_CLASSES);
    else effc = (CLS_W+1)'(ncls_q);
    if (nfeat_q == 5'd0) efff = (FEAT_W+1)'(1);
    else if ({1'b0, nfeat_q} > 6'(MAX_FEATURES)) efff = (FEAT_W+1)'(MAX_FEATURES);
    else efff = (FEAT_W+1)'(nfeat_q);
    pos_n   = ({1'b0, pos_q} >= efff) ? '0 : pos_q;
    last_n  = ((FEAT_W+1)'(pos_n) + (FEAT_W+1)'(1)) >= efff;
    pos_adv = last_n ? '0 : pos_n + FEAT_W'(1);
  end

  // Memories.
  logic s_we, m_we;
  logic [ADDR_W-1:0] s_raddr, s_waddr, m_raddr, m_waddr;
  logic [31:0] s_wdata, s_rdata;
  logic [15:0] m_wdata, m_rdata;

  nmc_ram #(.Width(32), .Depth(DEPTH)) u_sum_ram (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .raddr_i(s_raddr), .rdata_o(s_rdata)
  );
  nmc_ram #(.Width(16), .Depth(DEPTH)) u_mean_ram (
    .clk_i, .we_i(m_we), .waddr_i(m_waddr), .wdata_i(m_wdata),
    .raddr_i(m_raddr), .rdata_o(m_rdata)
  );

  logic [ADDR_W-1:0] t_addr;
  logic [31:0] sum_rd;
  logic [15:0] cnt_of_ent;
  logic [31:0] sum_abs;
  logic [16:0] rem_sh;
  logic rem_ge;
  logic [15:0] q_sat;
  logic signed [33:0] sq_full;
  logic [37:0] acc_sum;
  logic [36:0] acc_sat;
  logic srch_hit;

  always_comb begin
    t_addr     = {cls_q, ipos_q};
    sum_rd     = (state_q == ST_T_WR) ? (sum_vld_q[t_addr] ? s_rdata : 32'd0)
                                      : (sum_vld_q[ent_q] ? s_rdata : 32'd0);
    cnt_of_ent = counts_q[ent_q[ADDR_W-1:FEAT_W]];
    sum_abs    = sum_rd[31] ? (32'd0 - sum_rd) : sum_rd;
    rem_sh     = {rem_q, dvd_q[31]};
    rem_ge     = rem_sh >= {1'b0, den_q};
    if (neg_q) q_sat = (dvd_q > 32'd32768) ? 16'h8000 : 16'(32'd0 - dvd_q);
    else       q_sat = (dvd_q > 32'd32767) ? 16'h7FFF : dvd_q[15:0];
    sq_full  = d_q * d_q;
    acc_sum  = (ipos_q == '0 ? 38'd0 : {1'b0, acc_q[cnt_q]}) + {4'd0, sq_q};
    acc_sat  = acc_sum[37] ? ACC_MAX : acc_sum[36:0];
    srch_hit = ({1'b0, cnt_q} < effc) && (counts_q[cnt_q] != 16'd0) &&
               (!found_q || acc_q[cnt_q] < bdist_q);

    s_raddr = (state_q == ST_T_RD) ? t_addr : ent_q;
    s_we    = (state_q == ST_T_WR);
    s_waddr = t_addr;
    s_wdata = sum_rd + {{16{x_q[15]}}, x_q};

    m_raddr = {cnt_q, ipos_q};
    m_waddr = ent_q;
    m_we    = (state_q == ST_F_WR) || (state_q == ST_F_LD && cnt_of_ent == 16'd0);
    m_wdata = (state_q == ST_F_WR) ? q_sat : 16'd0;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ncls_q      <= 4'd8;
      nfeat_q     <= 5'd16;
      pos_q       <= '0;
      counts_q    <= '{default: '0};
      acc_q       <= '{default: '0};
      sum_vld_q   <= '0;
      mean_vld_q  <= '0;
      out_valid_o <= 1'b0;
      cnt_q       <= '0;
      ent_q       <= '0;
      bit_q       <= '0;
      found_q     <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_NUM_CLASSES) ncls_q <= cfg_data_i[3:0];
        else if (cfg_index_i == CFG_NUM_FEATURES) nfeat_q <= cfg_data_i;
      end
      // In the load state the output register is written below instead.
      if (out_valid_o && out_ready_i && state_q != ST_DONE) out_valid_o <= 1'b0;

      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            cls_q  <= class_index_i;
            x_q    <= feature_value_i;
            ipos_q <= pos_n;
            last_q <= last_n;
            case (opcode_i)
              OP_CLEAR: begin
                counts_q  <= '{default: '0};
                acc_q     <= '{default: '0};
                sum_vld_q <= '0;
                pos_q     <= '0;
              end
              OP_TRAIN: begin
                pos_q <= pos_adv;
                if ({1'b0, class_index_i} < effc && counts_q[class_index_i] != 16'hFFFF) begin
                  if (last_n) counts_q[class_index_i] <= counts_q[class_index_i] + 16'd1;
                  state_q <= ST_T_RD;
                end
              end
              OP_FINALIZE: begin
                pos_q   <= '0;
                ent_q   <= '0;
                state_q <= ST_F_RD;
              end
              default: begin
                pos_q   <= pos_adv;
                cnt_q   <= '0;
                state_q <= ST_C_RD;
              end
            endcase
          end
        end
        ST_T_RD: state_q <= ST_T_WR;
        ST_T_WR: begin
          sum_vld_q[t_addr] <= 1'b1;
          state_q <= ST_IDLE;
        end
        ST_F_RD: state_q <= ST_F_LD;
        ST_F_LD: begin
          if (cnt_of_ent == 16'd0) begin
            mean_vld_q[ent_q] <= 1'b1;
            ent_q   <= ent_q + ADDR_W'(1);
            state_q <= (ent_q == ADDR_W'(DEPTH-1)) ? ST_IDLE : ST_F_RD;
          end else begin
            dvd_q   <= sum_abs;
            neg_q   <= sum_rd[31];
            den_q   <= cnt_of_ent;
            rem_q   <= '0;
            bit_q   <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          // Restoring division, one quotient bit per cycle shifted into the dividend.
          rem_q <= rem_ge ? 16'(rem_sh - {1'b0, den_q}) : rem_sh[15:0];
          dvd_q <= {dvd_q[30:0], rem_ge};
          bit_q <= bit_q + 5'd1;
          if (bit_q == 5'd31) state_q <= ST_F_WR;
        end
        ST_F_WR: begin
          mean_vld_q[ent_q] <= 1'b1;
          ent_q   <= ent_q + ADDR_W'(1);
          state_q <= (ent_q == ADDR_W'(DEPTH-1)) ? ST_IDLE : ST_F_RD;
        end
        ST_C_RD: state_q <= ST_C_DF;
        ST_C_DF: begin
          d_q <= 17'(x_q) - (mean_vld_q[m_raddr] ? 17'(signed'(m_rdata)) : 17'sd0);
          state_q <= ST_C_SQ;
        end
        ST_C_SQ: begin
          sq_q    <= 34'(sq_full);
          state_q <= ST_C_AC;
        end
        ST_C_AC: begin
          acc_q[cnt_q] <= acc_sat;
          cnt_q <= cnt_q + CLS_W'(1);
          if (cnt_q == CLS_W'(MAX_CLASSES-1)) begin
            found_q <= 1'b0;
            state_q <= last_q ? ST_SRCH : ST_IDLE;
          end else begin
            state_q <= ST_C_RD;
          end
        end
        ST_SRCH: begin
          if (srch_hit) begin
            found_q <= 1'b1;
            bcls_q  <= cnt_q;
            bdist_q <= acc_q[cnt_q];
          end
          cnt_q <= cnt_q + CLS_W'(1);
          if (cnt_q == CLS_W'(MAX_CLASSES-1)) state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_o || out_ready_i) begin
            out_valid_o     <= 1'b1;
            best_class_o    <= found_q ? 3'(bcls_q) : 3'd0;
            best_distance_o <= !found_q ? 36'd0 :
                               (bdist_q[36] ? DIST_MAX : bdist_q[35:0]);
            no_class_o      <= !found_q;
            state_q         <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_no_class_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_class_o |-> best_class_o == 3'd0 && best_distance_o == 36'd0)
    else $error("no_class result carries nonzero fields");
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> den_q != 16'd0)
    else $error("divider running with zero count");
  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE && !out_valid_o |=> out_valid_o && state_q == ST_IDLE)
    else $error("result not loaded into free output register");
endmodule
`default_nettype wire
